[design/poi_pkg.sv]
package poi_pkg;

    // CORDIC rotation steps and the width of the rotating vector.
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int CW           = 35;           // signed vector width, Q.28 speeds plus growth
    localparam int MAG_W        = CW - 1;       // vector magnitude width
    localparam int ATAN_IDX_W   = 5;            // table holds 24 entries

    // Shared multiplier: 17 bit by 32 bit unsigned, 17 bit shift on the high half.
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 32;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 64;
    localparam int DX_W     = 21;               // rounded position step magnitude

    localparam logic [MUL_B_W-1:0] GAIN_Q30       = 32'd652032874;
    localparam logic [MUL_B_W-1:0] RAD_TO_BAM_Q30 = 32'd2734261102;
    localparam logic [15:0]        TIME_STEP_RST  = 16'd1311;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ROT  = 3'b010,
        ST_MUL  = 3'b100
    } poi_state_t;

    typedef enum logic [3:0] {
        MS_GX_LO = 4'd0,
        MS_GX_HI = 4'd1,
        MS_GY_LO = 4'd2,
        MS_GY_HI = 4'd3,
        MS_XDT   = 4'd4,
        MS_YDT   = 4'd5,
        MS_WDT   = 4'd6,
        MS_DH_LO = 4'd7,
        MS_DH_HI = 4'd8,
        MS_FIN   = 4'd9
    } poi_step_t;

    // Arctangent of 2^-i in binary angle units (2^32 per turn).
    function automatic logic [31:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

[design/poi_cordic.sv]
module poi_cordic
    import poi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [31:0]   z_in,
    output logic                 done,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out
);

    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [31:0]   z_reg, z_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic signed [CW-1:0] xs, ys;
    logic signed [31:0]   ang;

    // one shift-add step per cycle, floor shifts
    always_comb begin
        xs        = x_reg >>> iter_reg;
        ys        = y_reg >>> iter_reg;
        ang       = signed'(atan_bam(ATAN_IDX_W'(iter_reg)));
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = x_in;
            y_next    = y_in;
            z_next    = z_in;
            iter_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[31]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
            if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                iter_next = iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

[design/planar_odometry_integrator.sv]
// Planar dead-reckoning integrator. Each input beat carries forward speed, side
// speed and turn rate (signed Q4.12); side speed and turn rate are negated inside.
// The velocity is rotated by the stored heading (quadrant fold, then CORDIC_STEPS
// shift-add CORDIC steps), gain corrected, scaled by time_step (Q0.16) and added
// to the saturating Q16.16 x and y positions; the heading, a 32 bit binary angle,
// advances by the negated turn rate times time_step and wraps. Each input beat
// yields exactly one output beat with the updated pose; the heading output is the
// top 16 bits of the stored angle. From acceptance to m_tvalid a beat passes
// through the rotation unit at one CORDIC step per cycle, a hand-over, nine
// passes through the single 17 x 32 bit multiplier for gain, time step and yaw
// conversion, and the final update, which can stall. s_tready is low for that
// whole span. A finished result waits in the output register; a new beat may be
// accepted meanwhile, and its final update holds until the previous result is
// taken. time_step resets to 1311 (about 0.02 s) and is written through
// time_step_we / time_step_wdata; the user must write it only while idle, as
// the block itself does not enforce this.
module planar_odometry_integrator
    import poi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        time_step_we,
    input  logic [15:0] time_step_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // forward_speed[15:0], side_speed[31:16], turn_rate[47:32]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // pos_x[31:0], pos_y[63:32], heading[79:64]
);

    poi_state_t state_reg, state_next;
    poi_step_t  step_reg, step_next;

    logic [15:0]        time_step_reg;
    logic signed [31:0] x_accum_reg, x_accum_next;
    logic signed [31:0] y_accum_reg, y_accum_next;
    logic [31:0]        heading_reg, heading_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // per-beat working registers
    logic [MUL_A_W-1:0] wz_mag_reg;
    logic               wz_neg_reg;
    logic               x_neg_reg, y_neg_reg;
    logic [31:0]        xg_reg, yg_reg;
    logic [DX_W-1:0]    dx_reg, dy_reg;
    logic [30:0]        p_reg;
    logic [ACC_W-1:0]   acc_reg, acc_next;

    // input unpacking and quadrant fold
    logic               accept;
    logic signed [16:0] vx, vy, vx0, vy0, yaw_ext;
    logic               quad;
    logic signed [CW-1:0] cx_in, cy_in;
    logic signed [31:0] cz_in;

    logic               cordic_done;
    logic signed [CW-1:0] cx, cy;
    logic [MAG_W-1:0]   cx_mag, cy_mag;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_acc, mul_shift;
    logic [MUL_P_W-1:0] prod;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W-1:0]   rnd30, rnd28;

    // final update
    logic               out_free;
    logic [31:0]        dh;
    logic signed [DX_W:0] dx_s, dy_s;
    logic signed [32:0] x_sum, y_sum;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Negate side speed (turn rate is negated later by its sign flag); -(-32768) stays +32768 in 17 bits.
    // Fold headings beyond a quarter turn by flipping the vector and the top bit.
    always_comb begin
        vx      = 17'(signed'(s_tdata[15:0]));
        vy      = -17'(signed'(s_tdata[31:16]));
        yaw_ext = 17'(signed'(s_tdata[47:32]));
        quad    = heading_reg[31] ^ heading_reg[30];
        vx0     = quad ? -vx : vx;
        vy0     = quad ? -vy : vy;
        cx_in   = signed'({{(CW-33){vx0[16]}}, vx0, 16'b0});
        cy_in   = signed'({{(CW-33){vy0[16]}}, vy0, 16'b0});
        cz_in   = signed'({heading_reg[31] ^ quad, heading_reg[30:0]});
    end

    poi_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .x_in    (cx_in),
        .y_in    (cy_in),
        .z_in    (cz_in),
        .done    (cordic_done),
        .x_out   (cx),
        .y_out   (cy)
    );

    assign cx_mag = cx[CW-1] ? MAG_W'(-cx) : MAG_W'(cx);
    assign cy_mag = cy[CW-1] ? MAG_W'(-cy) : MAG_W'(cy);

    // Rounding of the accumulator, halves away from zero on the magnitude.
    assign rnd30 = (acc_reg + (ACC_W'(1) << 29)) >> 30;
    assign rnd28 = (acc_reg + (ACC_W'(1) << 27)) >> 28;

    // Multiplier operand select per sequencer step.
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_acc   = 1'b0;
        mul_shift = 1'b0;
        unique case (step_reg)
            MS_GX_LO: begin
                mul_a = cx_mag[MUL_A_W-1:0];
                mul_b = GAIN_Q30;
            end
            MS_GX_HI: begin
                mul_a     = MUL_A_W'(cx_mag[MAG_W-1:MUL_A_W]);
                mul_b     = GAIN_Q30;
                mul_acc   = 1'b1;
                mul_shift = 1'b1;
            end
            MS_GY_LO: begin
                mul_a = cy_mag[MUL_A_W-1:0];
                mul_b = GAIN_Q30;
            end
            MS_GY_HI: begin
                mul_a     = MUL_A_W'(cy_mag[MAG_W-1:MUL_A_W]);
                mul_b     = GAIN_Q30;
                mul_acc   = 1'b1;
                mul_shift = 1'b1;
            end
            MS_XDT: begin
                mul_a = MUL_A_W'(time_step_reg);
                mul_b = xg_reg;
            end
            MS_YDT: begin
                mul_a = MUL_A_W'(time_step_reg);
                mul_b = yg_reg;
            end
            MS_WDT: begin
                mul_a = wz_mag_reg;
                mul_b = MUL_B_W'(time_step_reg);
            end
            MS_DH_LO: begin
                mul_a = acc_reg[MUL_A_W-1:0];
                mul_b = RAD_TO_BAM_Q30;
            end
            MS_DH_HI: begin
                mul_a     = MUL_A_W'(p_reg[30:MUL_A_W]);
                mul_b     = RAD_TO_BAM_Q30;
                mul_acc   = 1'b1;
                mul_shift = 1'b1;
            end
            MS_FIN: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod     = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        addend   = mul_shift ? ACC_W'({prod, {MUL_A_W{1'b0}}}) : ACC_W'(prod);
        acc_next = mul_acc ? acc_reg + addend : addend;
    end

    // Final update: signed steps, saturating position, wrapping heading.
    always_comb begin
        dh    = wz_neg_reg ? -rnd30[31:0] : rnd30[31:0];
        dx_s  = x_neg_reg ? -signed'({1'b0, dx_reg}) : signed'({1'b0, dx_reg});
        dy_s  = y_neg_reg ? -signed'({1'b0, dy_reg}) : signed'({1'b0, dy_reg});
        x_sum = 33'(x_accum_reg) + 33'(dx_s);
        y_sum = 33'(y_accum_reg) + 33'(dy_s);
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        x_accum_next  = x_accum_reg;
        y_accum_next  = y_accum_reg;
        heading_next  = heading_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT: begin
                // hold until the rotation unit has run all its steps
                if (cordic_done) begin
                    state_next = ST_MUL;
                    step_next  = MS_GX_LO;
                end
            end
            ST_MUL: begin
                if (step_reg == MS_FIN) begin
                    // hold the update while the previous result still waits
                    if (out_free) begin
                        x_accum_next  = (x_sum[32] != x_sum[31])
                                        ? {x_sum[32], {31{~x_sum[32]}}} : x_sum[31:0];
                        y_accum_next  = (y_sum[32] != y_sum[31])
                                        ? {y_sum[32], {31{~y_sum[32]}}} : y_sum[31:0];
                        heading_next  = heading_reg + dh;
                        m_tvalid_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    step_next = poi_step_t'(step_reg + 4'd1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= MS_GX_LO;
            time_step_reg <= TIME_STEP_RST;
            x_accum_reg   <= '0;
            y_accum_reg   <= '0;
            heading_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            x_accum_reg   <= x_accum_next;
            y_accum_reg   <= y_accum_next;
            heading_reg   <= heading_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (time_step_we) begin
                time_step_reg <= time_step_wdata;
            end
        end
    end

    // Datapath registers; capture the rounded products as the steps advance.
    // Hold the accumulator on the final step so the heading increment survives a stall.
    always_ff @(posedge aclk) begin
        if (accept) begin
            wz_neg_reg <= !yaw_ext[16] && (yaw_ext != '0);
            wz_mag_reg <= yaw_ext[16] ? unsigned'(-yaw_ext) : unsigned'(yaw_ext);
        end
        if (state_reg == ST_MUL) begin
            if (step_reg != MS_FIN) begin
                acc_reg <= acc_next;
            end
            unique case (step_reg)
                MS_GX_LO: x_neg_reg <= cx[CW-1];
                MS_GY_LO: begin
                    xg_reg    <= rnd30[31:0];
                    y_neg_reg <= cy[CW-1];
                end
                MS_XDT:   yg_reg <= rnd30[31:0];
                MS_YDT:   dx_reg <= rnd28[DX_W-1:0];
                MS_WDT:   dy_reg <= rnd28[DX_W-1:0];
                MS_DH_LO: p_reg  <= acc_reg[30:0];
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {heading_reg[31:16], y_accum_reg, x_accum_reg};

endmodule

[design/poi_checker.sv]
module poi_checker
    import poi_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a beat is in flight");

    // returning to idle always leaves a result behind
    a_idle_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) && $past(aresetn) |-> m_tvalid)
        else $error("beat finished without a result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");

    // a new result straight after a taken one only when a beat has just finished
    a_new_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid || s_tready)
        else $error("result appeared while still busy");

    // the pose moves only together with a valid result
    a_pose_moves_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(m_tdata) |-> m_tvalid)
        else $error("pose changed without a result");

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
